FILE: sv/lcme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcme_pkg
// shared types, codes and constants of the lle cost matrix engine
// ----------------------------------------------------------------------------
package lcme_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int IDX_W   = 6;
    localparam int PC_W    = 7;
    localparam int COST_W  = 40;
    localparam int IN_WT_W = 16;

    localparam logic [PC_W-1:0] PC_RESET = 7'd64;

    // fixed-point alignment of the delta and weight terms
    localparam int ONE_SHIFT = 24;
    localparam int WT_SHIFT  = 12;

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIAG,
        ST_LOOP,
        ST_DRAIN
    } ctl_state_t;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_DIAG,
        TAG_PROD
    } tag_t;

    typedef struct packed {
        logic wr_en;
        logic latch;
        logic rd_diag;
        logic rd_prod;
        logic emit_zero;
        logic emit_result;
    } cmd_t;

    typedef struct packed {
        logic query_ok;
        logic k_last;
        logic pipe_busy;
    } status_t;

endpackage

FILE: sv/lcme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcme_ctrl
// sequencer for weight writes and cost matrix queries
// ----------------------------------------------------------------------------
module lcme_ctrl
    import lcme_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    action,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (action == ACT_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else if (status.query_ok)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = ST_DIAG;
                    end
                    else
                    begin
                        cmd.emit_zero = 1'b1;
                    end
                end
            end
            ST_DIAG:
            begin
                cmd.rd_diag = 1'b1;
                state_next  = ST_LOOP;
            end
            ST_LOOP:
            begin
                cmd.rd_prod = 1'b1;
                if (status.k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last product to reach the accumulator
                if (!status.pipe_busy)
                begin
                    cmd.emit_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/lcme_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcme_datapath
// weight memory, multiply-accumulate pipeline and result register
// ----------------------------------------------------------------------------
module lcme_datapath
    import lcme_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic                     cfg_wr_en,
    input  logic [PC_W-1:0]          cfg_wr_data,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [IN_WT_W-1:0] weight_value,
    output logic                     result_valid,
    output logic signed [COST_W-1:0] cost_value,
    output logic                     saturated
);

    localparam int SW      = (WEIGHT_BITS < IN_WT_W) ? WEIGHT_BITS : IN_WT_W;
    localparam int IW      = $clog2(MAX_POINTS);
    localparam int NW      = $clog2(MAX_POINTS + 1);
    localparam int DEPTH   = 1 << (2 * IW);
    localparam int ACC_RAW = 2 * SW + IW + 3;
    localparam int ACC_W   = (ACC_RAW > COST_W + 1) ? ACC_RAW : COST_W + 1;

    localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) << ONE_SHIFT;

    logic [PC_W-1:0]          point_count_reg;
    logic [NW-1:0]            n_eff;
    logic [IW-1:0]            i_reg;
    logic [IW-1:0]            j_reg;
    logic                     diag_reg;
    logic [IW-1:0]            k_reg;
    logic [2*IW-1:0]          addr_a;
    logic [2*IW-1:0]          addr_b;
    logic [2*IW-1:0]          wr_addr;
    logic                     wr_ok;
    logic signed [SW-1:0]     mem [DEPTH];
    logic signed [SW-1:0]     rdata_a_reg;
    logic signed [SW-1:0]     rdata_b_reg;
    tag_t                     tag_reg;
    tag_t                     tag_next;
    logic signed [2*SW-1:0]   prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  wa_ext;
    logic signed [ACC_W-1:0]  wb_ext;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     fits;
    logic signed [COST_W-1:0] sat_value;
    logic                     result_valid_reg;
    logic signed [COST_W-1:0] cost_reg;
    logic                     sat_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= PC_RESET;
        end
        else if (cfg_wr_en)
        begin
            point_count_reg <= cfg_wr_data;
        end
    end

    assign n_eff = (int'(point_count_reg) > MAX_POINTS) ? NW'(MAX_POINTS)
                                                        : NW'(point_count_reg);

    assign status.query_ok  = (int'(row_index) < int'(n_eff)) &&
                              (int'(col_index) < int'(n_eff));
    assign status.k_last    = (k_reg == IW'(n_eff - NW'(1)));
    assign status.pipe_busy = (tag_reg != TAG_NONE) || prod_valid_reg;

    // query indices and row counter
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            i_reg    <= IW'(row_index);
            j_reg    <= IW'(col_index);
            diag_reg <= (row_index == col_index);
            k_reg    <= '0;
        end
        else if (cmd.rd_prod)
        begin
            k_reg <= k_reg + IW'(1);
        end
    end

    // weight memory, one write and two registered reads
    assign wr_ok   = (int'(row_index) < MAX_POINTS) && (int'(col_index) < MAX_POINTS);
    assign wr_addr = {IW'(row_index), IW'(col_index)};
    assign addr_a  = cmd.rd_prod ? {k_reg, i_reg} : {i_reg, j_reg};
    assign addr_b  = cmd.rd_prod ? {k_reg, j_reg} : {j_reg, i_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[wr_addr] <= weight_value[SW-1:0];
        end
        rdata_a_reg <= mem[addr_a];
        rdata_b_reg <= mem[addr_b];
    end

    always_comb
    begin
        tag_next = TAG_NONE;
        if (cmd.rd_diag)
        begin
            tag_next = TAG_DIAG;
        end
        else if (cmd.rd_prod)
        begin
            tag_next = TAG_PROD;
        end
    end

    assign wa_ext   = {{(ACC_W-SW){rdata_a_reg[SW-1]}}, rdata_a_reg};
    assign wb_ext   = {{(ACC_W-SW){rdata_b_reg[SW-1]}}, rdata_b_reg};
    assign prod_ext = {{(ACC_W-2*SW){prod_reg[2*SW-1]}}, prod_reg};

    // read tag and product valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg        <= TAG_NONE;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            tag_reg        <= tag_next;
            prod_valid_reg <= (tag_reg == TAG_PROD);
        end
    end

    // multiply then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= rdata_a_reg * rdata_b_reg;
        if (tag_reg == TAG_DIAG)
        begin
            acc_reg <= (diag_reg ? ONE_ACC : '0) - (wa_ext <<< WT_SHIFT)
                       - (wb_ext <<< WT_SHIFT);
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    // clip to the result range
    assign fits      = (acc_reg[ACC_W-1:COST_W-1] == '0) ||
                       (acc_reg[ACC_W-1:COST_W-1] == '1);
    assign sat_value = fits ? acc_reg[COST_W-1:0]
                            : {acc_reg[ACC_W-1], {(COST_W-1){~acc_reg[ACC_W-1]}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit_zero || cmd.emit_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_zero)
        begin
            cost_reg <= '0;
            sat_reg  <= 1'b0;
        end
        else if (cmd.emit_result)
        begin
            cost_reg <= sat_value;
            sat_reg  <= ~fits;
        end
    end

    assign result_valid = result_valid_reg;
    assign cost_value   = cost_reg;
    assign saturated    = sat_reg;

endmodule

FILE: sv/lle_cost_matrix_engine.sv
`timescale 1ns / 1ps
// a query in range raises the result strobe after the diagonal read, a walk over n rows
//   (n the point count clamped to MAX_POINTS, one row per cycle through the memory) and
//   the pipeline drain, busy high until then; one weight write per cycle while idle;
//   a query outside the point count puts out zero right after the taking edge, block left free
// reset clears the sequencer, the pipeline valids and the result strobe; point_count
//   resets to 64; the weight memory is not cleared, the receiver cannot stall
// ----------------------------------------------------------------------------
// lle_cost_matrix_engine
// weight store and cost matrix entry engine for locally linear embedding
// ----------------------------------------------------------------------------
module lle_cost_matrix_engine
    import lcme_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config word
    input  logic                      cfg_wr_en,
    input  logic [PC_W-1:0]           cfg_wr_data,
    // command word, taken when start is high and busy is low
    input  logic                      start,
    output logic                      busy,
    input  logic                      action,
    input  logic [IDX_W-1:0]          row_index,
    input  logic [IDX_W-1:0]          col_index,
    input  logic signed [IN_WT_W-1:0] weight_value,
    // result word, valid for one cycle
    output logic                      result_valid,
    output logic signed [COST_W-1:0]  cost_value,
    output logic                      saturated
);

    cmd_t    cmd;
    status_t status;

    // controller: idle, diagonal read, row walk, pipeline drain
    lcme_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath: memory reads W[k][i] and W[k][j] each row cycle, one multiplier,
    // accumulator seeded with delta minus the two shifted weights
    lcme_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .row_index    (row_index),
        .col_index    (col_index),
        .weight_value (weight_value),
        .result_valid (result_valid),
        .cost_value   (cost_value),
        .saturated    (saturated)
    );

endmodule

FILE: sv/lcme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcme_checker
// port-level checks of the cost matrix engine
// ----------------------------------------------------------------------------
module lcme_checker
    import lcme_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      action,
    input logic                      result_valid,
    input logic signed [COST_W-1:0]  cost_value,
    input logic                      saturated
);

    // a write never yields a result word
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_WRITE) |=> !result_valid)
        else $error("result after weight write");

    // an accepted query either occupies the block or answers at once
    a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_QUERY) |=> (busy || result_valid))
        else $error("query dropped");

    // the end of a query walk delivers its result
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy fell without result");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (cost_value == {1'b0, {(COST_W-1){1'b1}}} ||
             cost_value == {1'b1, {(COST_W-1){1'b0}}}))
        else $error("saturated value off limit");

endmodule

bind lle_cost_matrix_engine lcme_checker u_lcme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .result_valid (result_valid),
    .cost_value   (cost_value),
    .saturated    (saturated)
);
